@@ rtl/bmtd_pkg.sv @@
// Shared types and constants of the block mean threshold detector.
`default_nettype none

package bmtd_pkg;

  // Sample and mean width, attempt count width.
  localparam int unsigned SMP_W  = 12;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  // Register indexes on the configuration port (byte address bit 2).
  localparam logic REG_THRESHOLD    = 1'b0;
  localparam logic REG_BLOCK_LENGTH = 1'b1;

  // Register reset values.
  localparam logic [SMP_W-1:0] THRESHOLD_RST    = 12'd2048;
  localparam logic [CNT_W-1:0] BLOCK_LENGTH_RST = 8'd100;

  typedef struct packed {
    logic [SMP_W-1:0] sample;
    logic             read_error;
  } bmtd_in_t;

  typedef struct packed {
    logic [SMP_W-1:0] block_mean;
    logic             indicator_on;
  } bmtd_out_t;

  // Handshake between the sequencer and the serial divider.
  typedef struct packed {
    logic             start;
    logic [SMP_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } bmtd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [SMP_W-1:0] quotient;
  } bmtd_div_rsp_t;

endpackage

`default_nettype wire

@@ rtl/bmtd_div.sv @@
// Bit-serial restoring divider: unsigned 12-bit dividend by 8-bit divisor.
`default_nettype none

module bmtd_div
  import bmtd_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bmtd_div_req_t req,
  output bmtd_div_rsp_t      rsp
);

  localparam int unsigned STEP_W = $clog2(SMP_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SMP_W - 1);

  logic [SMP_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  dsr_r, dsr_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;

  logic [CNT_W:0] trial;
  logic [CNT_W:0] trial_sub;
  logic           fits;

  // Shift one dividend bit into the partial remainder and try the subtract.
  assign trial     = {rem_r, quo_r[SMP_W-1]};
  assign trial_sub = trial - {1'b0, dsr_r};
  assign fits      = (trial >= {1'b0, dsr_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      step_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // Advance one quotient bit a cycle.
      quo_nxt  = {quo_r[SMP_W-2:0], fits};
      rem_nxt  = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    dsr_r  <= dsr_nxt;
    step_r <= step_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

@@ rtl/bmtd_regs.sv @@
// APB-style configuration registers: threshold and block length.
`default_nettype none

module bmtd_regs
  import bmtd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [SMP_W-1:0]  threshold,
  output logic      [CNT_W-1:0]  block_length
);

  logic [SMP_W-1:0] threshold_r, threshold_nxt;
  logic [CNT_W-1:0] blen_r, blen_nxt;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Decode the write on address bit 2.
  always_comb begin
    threshold_nxt = threshold_r;
    blen_nxt      = blen_r;
    if (wr_en) begin
      unique case (paddr[2])
        REG_THRESHOLD:    threshold_nxt = pwdata[SMP_W-1:0];
        REG_BLOCK_LENGTH: blen_nxt      = pwdata[CNT_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= THRESHOLD_RST;
      blen_r      <= BLOCK_LENGTH_RST;
    end else begin
      threshold_r <= threshold_nxt;
      blen_r      <= blen_nxt;
    end
  end

  // Return the selected register, zero extended.
  always_comb begin
    unique case (paddr[2])
      REG_THRESHOLD:    prdata = {{(DATA_W-SMP_W){1'b0}}, threshold_r};
      REG_BLOCK_LENGTH: prdata = {{(DATA_W-CNT_W){1'b0}}, blen_r};
      default:          prdata = '0;
    endcase
  end

  assign threshold    = threshold_r;
  assign block_length = blen_r;

endmodule

`default_nettype wire

@@ rtl/block_mean_threshold_detector.sv @@
// Top level: running block mean with threshold indicator.
//
// Usage: each input transaction on in_valid/in_ready carries one converter
// read attempt (sample, read_error). After block_length attempts one result
// transaction on out_valid/out_ready carries the block mean and indicator_on
// (mean <= threshold); other attempts give no result.
// Timing: a good read holds in_ready low after acceptance while the bit-serial
// divider forms the 12 quotient bits, the sequencer applies the step and the
// finish state runs, so a new attempt is taken only once the previous one is
// through. A failed read holds in_ready low only for its finish state. A block
// result is loaded into the output register from the last attempt's finish state.
// The result sits in an output register; new attempts are accepted while it
// waits. If a block ends while the previous result is still not taken, the
// block holds in its finish cycle and in_ready stays low until out_ready.
// Reset (rst_n low, synchronous) clears the mean, the attempt count and the
// output valid, and loads threshold 2048 and block_length 100.
// Configuration goes through an APB-style port at byte addresses 0 and 4;
// write it only while no attempt is in flight.
`default_nettype none

module block_mean_threshold_detector
  import bmtd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bmtd_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bmtd_out_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [SMP_W-1:0] mean_r, mean_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             neg_r, neg_nxt;
  logic             out_valid_r, out_valid_nxt;
  bmtd_out_t        out_data_r, out_data_nxt;

  logic [SMP_W-1:0] threshold;
  logic [CNT_W-1:0] block_length;
  bmtd_div_req_t    div_req;
  bmtd_div_rsp_t    div_rsp;

  logic             in_fire;
  logic [SMP_W:0]   diff;
  logic [SMP_W:0]   diff_mag;
  logic [CNT_W-1:0] count_inc;
  logic             block_end;
  logic             slot_free;
  logic [SMP_W:0]   mean_upd;

  bmtd_regs u_regs (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .threshold    (threshold),
    .block_length (block_length)
  );

  bmtd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;

  // Split sample minus mean into sign and magnitude for the divider.
  assign diff     = {1'b0, in_data.sample} - {1'b0, mean_r};
  assign diff_mag = diff[SMP_W] ? (~diff + 1'b1) : diff;

  assign div_req.start    = in_fire && !in_data.read_error;
  assign div_req.dividend = diff_mag[SMP_W-1:0];
  assign div_req.divisor  = count_r + 1'b1;

  // Apply the truncated step with its sign; the mean stays in sample range.
  assign mean_upd = neg_r ? ({1'b0, mean_r} - {1'b0, div_rsp.quotient})
                          : ({1'b0, mean_r} + {1'b0, div_rsp.quotient});

  assign count_inc = count_r + 1'b1;
  assign block_end = (count_inc >= block_length);
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    mean_nxt      = mean_r;
    count_nxt     = count_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    // Drop the result once taken.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          neg_nxt   = diff[SMP_W];
          state_nxt = in_data.read_error ? ST_FIN : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          mean_nxt  = mean_upd[SMP_W-1:0];
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!block_end) begin
          count_nxt = count_inc;
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          // Emit the block result and clear the running state.
          out_valid_nxt             = 1'b1;
          out_data_nxt.block_mean   = mean_r;
          out_data_nxt.indicator_on = (mean_r <= threshold);
          mean_nxt                  = '0;
          count_nxt                 = '0;
          state_nxt                 = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mean_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mean_r      <= mean_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // A good read always starts the divider.
  a_good_read_divides: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_data.read_error |=> state_r == ST_DIV)
    else $error("good read did not enter divide state");

  // The divider reports completion only while the sequencer waits for it.
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider done outside divide state");

  // A finished block clears the count and raises the result.
  a_block_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && block_end && slot_free
    |=> out_valid_r && count_r == '0 && mean_r == '0)
    else $error("block end did not emit and clear");

  // A block that cannot emit holds in its finish cycle.
  a_block_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && block_end && !slot_free |=> state_r == ST_FIN)
    else $error("stalled block left finish state");
`endif

endmodule

`default_nettype wire
